// File: sv/stable_sorted_priority_queue_defines.svh
// Assertion macros for the stable sorted priority queue.
// No dependencies; included by the top level, which provides i_clk and i_rst_n.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SSPQ_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SSPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sspq_pkg.sv
// Shared types and codes for the stable sorted priority queue.
// No dependencies.
package sspq_pkg;

    localparam int PRIO_FIELD_W = 8;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                    cmd;
        logic [PRIO_FIELD_W-1:0] priority_req;
        logic [15:0]             tag;
    } t_req_word;

    typedef struct packed {
        logic [15:0]             out_tag;
        logic [PRIO_FIELD_W-1:0] out_priority;
        t_status                 status;
        logic [4:0]              occupancy;
    } t_rsp_word;

    // broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

// File: sv/sspq_ifs.sv
// Valid/ready channel interfaces for request and response words.
// Depends on sspq_pkg.
interface sspq_req_if;
    logic                 valid;
    logic                 ready;
    sspq_pkg::t_req_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sspq_rsp_if;
    logic                 valid;
    logic                 ready;
    sspq_pkg::t_rsp_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/sspq_cell.sv
// One slot of the sorted shift chain: holds a priority and tag, shifts right
// on an insert at or ahead of it, shifts left on pop. Depends on sspq_pkg.
module sspq_cell #(
    parameter int PW = 8
) (
    input  logic                i_clk,
    input  sspq_pkg::t_cell_ctl i_ctl,
    input  logic                i_occ,
    input  logic [PW-1:0]       i_new_prio,
    input  logic [15:0]         i_new_tag,
    input  logic                i_left_keep,
    input  logic [PW-1:0]       i_left_prio,
    input  logic [15:0]         i_left_tag,
    input  logic [PW-1:0]       i_right_prio,
    input  logic [15:0]         i_right_tag,
    output logic                o_keep,
    output logic [PW-1:0]       o_prio,
    output logic [15:0]         o_tag
);
    import sspq_pkg::*;

    logic [PW-1:0] r_prio, n_prio;
    logic [15:0]   r_tag, n_tag;

    // held entry stays ahead of an equal or larger new priority
    assign o_keep = i_occ && (r_prio <= i_new_prio);
    assign o_prio = r_prio;
    assign o_tag  = r_tag;

    always_comb begin
        n_prio = r_prio;
        n_tag  = r_tag;
        if (i_ctl.push && !o_keep) begin
            if (i_left_keep) begin
                n_prio = i_new_prio;
                n_tag  = i_new_tag;
            end else begin
                n_prio = i_left_prio;
                n_tag  = i_left_tag;
            end
        end else if (i_ctl.pop) begin
            n_prio = i_right_prio;
            n_tag  = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

endmodule

// File: sv/stable_sorted_priority_queue.sv
// Stable sorted priority queue. Holds up to DEPTH entries (priority, tag) in a
// row of shift cells kept in ascending priority order; a push lands behind
// every entry of equal or lower priority, so equal priorities leave in
// arrival order, and a pop returns the front entry. Each request word yields
// one response word with status (ok, pop on empty, push on full dropped) and
// the occupancy after the operation. Throughput is one word per cycle while
// responses are read out: every cell compares its priority against the incoming
// one in parallel and moves in the same cycle, so the cycle is set by one PW-bit
// compare per cell plus the shift mux. The response is registered. A new request
// is taken in the same cycle the held response is drained; while a response
// waits unread, request ready stays low. Priorities keep only the low PW bits,
// PRIO_BITS capped at PRIO_FIELD_W. Depends on sspq_pkg, sspq_ifs, sspq_cell
// and the defines header.
`include "stable_sorted_priority_queue_defines.svh"

module stable_sorted_priority_queue #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sspq_req_if.sink    i_req,
    sspq_rsp_if.source  o_rsp
);
    import sspq_pkg::*;

    // stored priority width and count width
    localparam int PW = (PRIO_BITS < PRIO_FIELD_W) ? PRIO_BITS : PRIO_FIELD_W;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid;
    t_rsp_word     r_out, n_out;

    logic          w_accept, w_full, w_empty;
    t_cell_ctl     w_ctl;
    logic [31:0]   w_cnt_wide;

    // per-cell wires, one entry per fixed cell position
    logic          w_keep [DEPTH];
    logic [PW-1:0] w_prio [DEPTH];
    logic [15:0]   w_tag  [DEPTH];

    // response register frees when drained or empty
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_ctl.push = w_accept && (i_req.data.cmd == CMD_PUSH) && !w_full;
    assign w_ctl.pop  = w_accept && (i_req.data.cmd == CMD_POP) && !w_empty;

    // shift chain: cell 0 is the front of the queue
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic          w_lk;
        logic [PW-1:0] w_lp, w_rp;
        logic [15:0]   w_lt, w_rt;

        if (g == 0) begin : g_first
            assign w_lk = 1'b1;
            assign w_lp = '0;
            assign w_lt = '0;
        end else begin : g_mid
            assign w_lk = w_keep[g-1];
            assign w_lp = w_prio[g-1];
            assign w_lt = w_tag[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rp = '0;
            assign w_rt = '0;
        end else begin : g_inner
            assign w_rp = w_prio[g+1];
            assign w_rt = w_tag[g+1];
        end

        sspq_cell #(
            .PW (PW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occ        (r_count > CW'(g)),
            .i_new_prio   (i_req.data.priority_req[PW-1:0]),
            .i_new_tag    (i_req.data.tag),
            .i_left_keep  (w_lk),
            .i_left_prio  (w_lp),
            .i_left_tag   (w_lt),
            .i_right_prio (w_rp),
            .i_right_tag  (w_rt),
            .o_keep       (w_keep[g]),
            .o_prio       (w_prio[g]),
            .o_tag        (w_tag[g])
        );
    end

    // next count and response word
    always_comb begin
        n_count = r_count;
        if (w_ctl.push) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    assign w_cnt_wide = 32'(n_count);

    always_comb begin
        n_out.out_tag      = '0;
        n_out.out_priority = '0;
        n_out.status       = ST_OK;
        n_out.occupancy    = w_cnt_wide[4:0];
        if (i_req.data.cmd == CMD_POP) begin
            if (w_empty) begin
                n_out.status = ST_EMPTY;
            end else begin
                n_out.out_tag      = w_tag[0];
                n_out.out_priority = PRIO_FIELD_W'(w_prio[0]);
            end
        end else if (w_full) begin
            n_out.status = ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    // checks
    `SSPQ_ASSERT(a_count_bound, 1'b1, r_count <= CW'(DEPTH), "occupancy above depth")
    `SSPQ_ASSERT(a_front_sorted, r_count >= CW'(2), w_prio[0] <= w_prio[1], "front out of order")
    `SSPQ_ASSERT_NEXT(a_pop_count, w_ctl.pop, r_count == CW'($past(r_count) - 1'b1),
        "pop did not decrement")
    `SSPQ_ASSERT(a_no_overrun, r_out_valid && !o_rsp.ready, !w_accept,
        "request taken over a stalled response")

endmodule
